[hw/rtl/etm_pkg.sv]
// Shared types and codes for the exhaustive template match block.
package etm_pkg;

    localparam int FUNC_W = 2;
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 9;
    localparam int CIDX_W = 3;
    localparam int SUM_W  = 32;

    localparam logic [FUNC_W-1:0] FN_WR_BASE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WR_TEMPL = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH   = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_BASE_W  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_BASE_H  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_TEMPL_W = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TEMPL_H = 3'd3;

    localparam logic [CFG_W-1:0] RST_BASE_DIM  = 9'd256;
    localparam logic [CFG_W-1:0] RST_TEMPL_DIM = 9'd16;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ACC   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        CS_SQ1  = 3'd0,
        CS_SQ2  = 3'd1,
        CS_P1L  = 3'd2,
        CS_P1H  = 3'd3,
        CS_P2L  = 3'd4,
        CS_P2H  = 3'd5,
        CS_HIGH = 3'd6,
        CS_CMP  = 3'd7
    } cmp_step_t;

endpackage

[hw/rtl/etm_cmp.sv]
// Multi-cycle exact score compare: d1^2*e2 > d2^2*e1 on one shared 32x32 multiplier.
module etm_cmp
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [etm_pkg::SUM_W-1:0] d1,
    input  logic [etm_pkg::SUM_W-1:0] e1,
    input  logic [etm_pkg::SUM_W-1:0] d2,
    input  logic [etm_pkg::SUM_W-1:0] e2,
    output logic                      done,
    output logic                      greater
);

    localparam int W  = etm_pkg::SUM_W;
    localparam int W2 = 2 * etm_pkg::SUM_W;

    logic                busy_reg;
    etm_pkg::cmp_step_t  step_reg;
    logic                done_reg;
    logic                gt_reg;
    logic [W2-1:0]       mul_reg;
    logic [W2-1:0]       s1_reg;
    logic [W2-1:0]       s2_reg;
    logic [W2-1:0]       p1l_reg;
    logic [W2-1:0]       p1h_reg;
    logic [W2-1:0]       p2l_reg;
    logic [W2-1:0]       h1_reg;
    logic [W2-1:0]       h2_reg;
    logic [W-1:0]        mul_a;
    logic [W-1:0]        mul_b;

    always_comb
    begin
        case (step_reg)
            etm_pkg::CS_SQ1:
            begin
                mul_a = d1;
                mul_b = d1;
            end
            etm_pkg::CS_SQ2:
            begin
                mul_a = d2;
                mul_b = d2;
            end
            etm_pkg::CS_P1L:
            begin
                mul_a = s1_reg[W-1:0];
                mul_b = e2;
            end
            etm_pkg::CS_P1H:
            begin
                mul_a = s1_reg[W2-1:W];
                mul_b = e2;
            end
            etm_pkg::CS_P2L:
            begin
                mul_a = s2_reg[W-1:0];
                mul_b = e1;
            end
            etm_pkg::CS_P2H:
            begin
                mul_a = s2_reg[W2-1:W];
                mul_b = e1;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= etm_pkg::CS_SQ1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= etm_pkg::CS_SQ1;
            end
            else if (busy_reg)
            begin
                if (step_reg == etm_pkg::CS_CMP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= etm_pkg::cmp_step_t'(step_reg + 3'd1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (step_reg)
            etm_pkg::CS_SQ2:  s1_reg  <= mul_reg;
            etm_pkg::CS_P1L:  s2_reg  <= mul_reg;
            etm_pkg::CS_P1H:  p1l_reg <= mul_reg;
            etm_pkg::CS_P2L:  p1h_reg <= mul_reg;
            etm_pkg::CS_P2H:  p2l_reg <= mul_reg;
            etm_pkg::CS_HIGH:
            begin
                h1_reg <= p1h_reg + {{W{1'b0}}, p1l_reg[W2-1:W]};
                h2_reg <= mul_reg + {{W{1'b0}}, p2l_reg[W2-1:W]};
            end
            etm_pkg::CS_CMP:
            begin
                gt_reg <= (h1_reg > h2_reg) ||
                          ((h1_reg == h2_reg) && (p1l_reg[W-1:0] > p2l_reg[W-1:0]));
            end
            default:
            begin
            end
        endcase
    end

    assign done    = done_reg;
    assign greater = gt_reg;

endmodule

[hw/rtl/exhaustive_template_match.sv]
// Top level of the exhaustive template match block with pixel stores and search sequencer.
// Base and template pixels load one item per cycle, when idle, into two stores of
// MAX_DIM*MAX_DIM bytes with one write and one read port each; pixels never written read
// as undefined. A search item runs a full scan unless the template exceeds the base: every
// placement sums templ*base and base*base over its window, one pixel per cycle through the
// read port of each store, then a drain and a compare state decide (first hit or zero dot),
// waiting on the exact 96-bit score compare on one shared multiplier otherwise. One result
// item follows a search. Writes are taken while a result waits; no new item during a search.
module exhaustive_template_match #(
    parameter int MAX_DIM = 256
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [etm_pkg::FUNC_W-1:0]  func,
    input  logic [7:0]                  col,
    input  logic [7:0]                  row,
    input  logic [etm_pkg::PIX_W-1:0]   pixel,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  best_col,
    output logic [7:0]                  best_row,
    output logic                        found,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [etm_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [etm_pkg::CFG_W-1:0]   cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int DW1    = DIM_W + 1;
    localparam int SW     = etm_pkg::SUM_W;

    logic [etm_pkg::PIX_W-1:0] base_mem  [0:DEPTH-1];
    logic [etm_pkg::PIX_W-1:0] templ_mem [0:DEPTH-1];

    logic [etm_pkg::CFG_W-1:0] bw_cfg_reg, bh_cfg_reg, tw_cfg_reg, th_cfg_reg;
    logic [DW1-1:0]            bw, bh, tw, th;
    logic [DIM_W-1:0]          x_max, y_max;

    etm_pkg::state_t   state_reg, state_next;
    logic [DIM_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [DIM_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic [SW-1:0]     best_dot_reg, best_dot_next;
    logic [SW-1:0]     best_en_reg, best_en_next;
    logic [DIM_W-1:0]  best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic [SW-1:0]     dot_reg, en_reg;
    logic              rd_vld_reg;
    logic [etm_pkg::PIX_W-1:0] base_q_reg, templ_q_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_col_reg, out_row_reg;
    logic              out_found_reg;
    logic              out_load, take, adv, acc_clr, cmp_start, cmp_done, cmp_gt;
    logic              in_acc, wr_ok;
    logic [ADDR_W-1:0] wr_addr, rd_base_addr, rd_templ_addr;

    function automatic logic [DW1-1:0] eff_dim(input logic [etm_pkg::CFG_W-1:0] v);
        if (v == '0)
            return DW1'(1);
        else if (32'(v) > MAX_DIM)
            return DW1'(MAX_DIM);
        else
            return DW1'(v);
    endfunction

    assign bw    = eff_dim(bw_cfg_reg);
    assign bh    = eff_dim(bh_cfg_reg);
    assign tw    = eff_dim(tw_cfg_reg);
    assign th    = eff_dim(th_cfg_reg);
    assign x_max = DIM_W'(bw - tw);
    assign y_max = DIM_W'(bh - th);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_cfg_reg <= etm_pkg::RST_BASE_DIM;
            bh_cfg_reg <= etm_pkg::RST_BASE_DIM;
            tw_cfg_reg <= etm_pkg::RST_TEMPL_DIM;
            th_cfg_reg <= etm_pkg::RST_TEMPL_DIM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                etm_pkg::CFG_BASE_W:  bw_cfg_reg <= cfg_data;
                etm_pkg::CFG_BASE_H:  bh_cfg_reg <= cfg_data;
                etm_pkg::CFG_TEMPL_W: tw_cfg_reg <= cfg_data;
                etm_pkg::CFG_TEMPL_H: th_cfg_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = (state_reg != etm_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign wr_ok    = (32'(col) < MAX_DIM) && (32'(row) < MAX_DIM);
    assign wr_addr  = ADDR_W'(32'(row) * MAX_DIM + 32'(col));
    assign rd_base_addr  = ADDR_W'((32'(y_reg) + 32'(i_reg)) * MAX_DIM +
                                   32'(x_reg) + 32'(j_reg));
    assign rd_templ_addr = ADDR_W'(32'(i_reg) * MAX_DIM + 32'(j_reg));

    always_ff @(posedge clk)
    begin
        if (in_acc && wr_ok && func == etm_pkg::FN_WR_BASE)
            base_mem[wr_addr] <= pixel;
        base_q_reg <= base_mem[rd_base_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && wr_ok && func == etm_pkg::FN_WR_TEMPL)
            templ_mem[wr_addr] <= pixel;
        templ_q_reg <= templ_mem[rd_templ_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        best_dot_next = best_dot_reg;
        best_en_next  = best_en_reg;
        best_x_next   = best_x_reg;
        best_y_next   = best_y_reg;
        out_load      = 1'b0;
        take          = 1'b0;
        adv           = 1'b0;
        cmp_start     = 1'b0;
        case (state_reg)
            etm_pkg::ST_IDLE:
            begin
                if (in_acc && func == etm_pkg::FN_SEARCH)
                begin
                    best_dot_next = '0;
                    best_en_next  = '0;
                    best_x_next   = '0;
                    best_y_next   = '0;
                    x_next        = '0;
                    y_next        = '0;
                    i_next        = '0;
                    j_next        = '0;
                    if (tw > bw || th > bh)
                        state_next = etm_pkg::ST_DONE;
                    else
                        state_next = etm_pkg::ST_ACC;
                end
            end
            etm_pkg::ST_ACC:
            begin
                if (DW1'(j_reg) + DW1'(1) == tw)
                begin
                    j_next = '0;
                    if (DW1'(i_reg) + DW1'(1) == th)
                    begin
                        i_next     = '0;
                        state_next = etm_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + DIM_W'(1);
                end
            end
            etm_pkg::ST_DRAIN:
            begin
                state_next = etm_pkg::ST_CMP;
            end
            etm_pkg::ST_CMP:
            begin
                if (dot_reg == '0)
                begin
                    adv = 1'b1;
                end
                else if (best_dot_reg == '0)
                begin
                    take = 1'b1;
                    adv  = 1'b1;
                end
                else
                begin
                    cmp_start  = 1'b1;
                    state_next = etm_pkg::ST_WAIT;
                end
            end
            etm_pkg::ST_WAIT:
            begin
                if (cmp_done)
                begin
                    take = cmp_gt;
                    adv  = 1'b1;
                end
            end
            etm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = etm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = etm_pkg::ST_IDLE;
            end
        endcase

        if (take)
        begin
            best_dot_next = dot_reg;
            best_en_next  = en_reg;
            best_x_next   = x_reg;
            best_y_next   = y_reg;
        end
        if (adv)
        begin
            if (x_reg == x_max)
            begin
                x_next = '0;
                if (y_reg == y_max)
                begin
                    state_next = etm_pkg::ST_DONE;
                end
                else
                begin
                    y_next     = y_reg + DIM_W'(1);
                    state_next = etm_pkg::ST_ACC;
                end
            end
            else
            begin
                x_next     = x_reg + DIM_W'(1);
                state_next = etm_pkg::ST_ACC;
            end
        end
    end

    assign acc_clr = (state_reg != etm_pkg::ST_ACC) && (state_next == etm_pkg::ST_ACC);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= etm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            best_dot_reg  <= '0;
            best_en_reg   <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= (state_reg == etm_pkg::ST_ACC);
            best_dot_reg  <= best_dot_next;
            best_en_reg   <= best_en_next;
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        i_reg <= i_next;
        j_reg <= j_next;
        if (acc_clr)
        begin
            dot_reg <= '0;
            en_reg  <= '0;
        end
        else if (rd_vld_reg)
        begin
            dot_reg <= dot_reg + SW'(16'(templ_q_reg) * 16'(base_q_reg));
            en_reg  <= en_reg + SW'(16'(base_q_reg) * 16'(base_q_reg));
        end
        if (out_load)
        begin
            out_col_reg   <= 8'(best_x_reg);
            out_row_reg   <= 8'(best_y_reg);
            out_found_reg <= (best_dot_reg != '0);
        end
    end

    etm_cmp u_cmp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmp_start),
        .d1      (dot_reg),
        .e1      (en_reg),
        .d2      (best_dot_reg),
        .e2      (best_en_reg),
        .done    (cmp_done),
        .greater (cmp_gt)
    );

    assign out_valid = out_valid_reg;
    assign best_col  = out_col_reg;
    assign best_row  = out_row_reg;
    assign found     = out_found_reg;

    ap_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == etm_pkg::ST_DONE))
        else $error("result raised outside the done state");

    ap_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == etm_pkg::ST_DRAIN) |-> rd_vld_reg)
        else $error("drain cycle without read data");

    ap_cmp_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_start |-> (best_dot_reg != '0) && (dot_reg != '0))
        else $error("score compare started without two nonzero scores");

    ap_wait_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_done |-> (state_reg == etm_pkg::ST_WAIT))
        else $error("compare finished while not waiting");

endmodule

[bench/tb.sv]
// Self-checking bench for the exhaustive template match block.
`timescale 1ns / 100ps

module tb;

    localparam int GRID = 256;
    localparam logic [etm_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [etm_pkg::FUNC_W-1:0] fn;
        logic [7:0]                 c;
        logic [7:0]                 r;
        logic [etm_pkg::PIX_W-1:0]  p;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] c;
        logic [7:0] r;
        logic       hit;
    } match_t;

    typedef struct {
        int bw, bh, tw, th;
        int send_idle, recv_stall;
        int n_rand;
        bit long_hold;
    } phase_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [etm_pkg::FUNC_W-1:0] func = '0;
    logic [7:0] col = '0;
    logic [7:0] row = '0;
    logic [etm_pkg::PIX_W-1:0] pixel = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [7:0] best_col;
    logic [7:0] best_row;
    logic found;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [etm_pkg::CIDX_W-1:0] cfg_index = '0;
    logic [etm_pkg::CFG_W-1:0] cfg_data = '0;

    logic [7:0] base_img [GRID*GRID];
    logic [7:0] templ_img [GRID*GRID];
    int dim_reg [4];
    pixel_item_t pending_items[$];
    match_t expected_matches[$];
    pixel_item_t next_item;
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_arm = 0;
    bit hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    phase_t phases[$];

    exhaustive_template_match DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .col(col), .row(row), .pixel(pixel),
        .out_valid(out_valid), .out_stall(out_stall),
        .best_col(best_col), .best_row(best_row), .found(found),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int clamp_dim(int v);
        if (v == 0)
            return 1;
        if (v > GRID)
            return GRID;
        return v;
    endfunction

    function automatic match_t search_best();
        int bw, bh, tw, th;
        bit [31:0] dot, en, bd, be, b, t;
        bit [95:0] lhs, rhs, d96, bd96;
        match_t m;
        bw = clamp_dim(dim_reg[0]);
        bh = clamp_dim(dim_reg[1]);
        tw = clamp_dim(dim_reg[2]);
        th = clamp_dim(dim_reg[3]);
        bd = 0;
        be = 0;
        m = '0;
        if (tw > bw || th > bh)
            return m;
        for (int y = 0; y <= bh - th; y++)
            for (int x = 0; x <= bw - tw; x++)
            begin
                dot = 0;
                en = 0;
                for (int i = 0; i < th; i++)
                    for (int j = 0; j < tw; j++)
                    begin
                        b = 32'(base_img[(y + i) * GRID + x + j]);
                        t = 32'(templ_img[i * GRID + j]);
                        dot += t * b;
                        en += b * b;
                    end
                if (dot == 0)
                    continue;
                d96 = 96'(dot);
                bd96 = 96'(bd);
                lhs = d96 * d96 * 96'(be);
                rhs = bd96 * bd96 * 96'(en);
                if (bd == 0 || lhs > rhs)
                begin
                    bd = dot;
                    be = en;
                    m.c = x[7:0];
                    m.r = y[7:0];
                    m.hit = 1'b1;
                end
            end
        return m;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (func == etm_pkg::FN_WR_BASE)
                    base_img[{row, col}] = pixel;
                else if (func == etm_pkg::FN_WR_TEMPL)
                    templ_img[{row, col}] = pixel;
                else if (func == etm_pkg::FN_SEARCH)
                    expected_matches.push_back(search_best());
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    func <= next_item.fn;
                    col <= next_item.c;
                    row <= next_item.r;
                    pixel <= next_item.p;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_arm && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_left <= 5000;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_matches.size() == 0)
            begin
                $error("unexpected result col=%0d row=%0d found=%0b", best_col, best_row, found);
                errors++;
            end
            else
            begin
                match_t m;
                m = expected_matches.pop_front();
                if (best_col !== m.c)
                begin
                    $error("best_col expected %0d got %0d", m.c, best_col);
                    errors++;
                end
                if (best_row !== m.r)
                begin
                    $error("best_row expected %0d got %0d", m.r, best_row);
                    errors++;
                end
                if (found !== m.hit)
                begin
                    $error("found expected %0b got %0b", m.hit, found);
                    errors++;
                end
            end
        end
    end

    task automatic write_dim(logic [etm_pkg::CIDX_W-1:0] idx, int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[etm_pkg::CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        dim_reg[idx] = v;
    endtask

    task automatic queue_item(logic [etm_pkg::FUNC_W-1:0] fn, int c, int r, int p);
        pixel_item_t it;
        it.fn = fn;
        it.c = c[7:0];
        it.r = r[7:0];
        it.p = p[7:0];
        pending_items.push_back(it);
    endtask

    // fill a whole store region; v < 0 gives random pixels
    task automatic fill(logic [etm_pkg::FUNC_W-1:0] fn, int w, int h, int v);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                queue_item(fn, c, r, (v < 0) ? $urandom_range(255) : v);
    endtask

    function automatic int rand_pix();
        case ($urandom_range(5))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_matches.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        int bw, bh, tw, th, k;
        phase_t ph;
        phases.push_back('{8, 6, 3, 2, 0, 0, 20, 0});
        phases.push_back('{0, 0, 0, 0, 60, 0, 20, 0});
        phases.push_back('{5, 4, 9, 2, 0, 60, 20, 0});
        phases.push_back('{511, 1, 300, 1, 32, 32, 10, 0});
        phases.push_back('{12, 10, 4, 3, 0, 0, 40, 1});
        phases.push_back('{8, 6, 2, 2, 60, 0, 20, 0});
        phases.push_back('{5, 5, 5, 5, 0, 60, 20, 0});
        phases.push_back('{9, 7, 4, 3, 32, 32, 20, 0});
        phases.push_back('{6, 8, 1, 3, 0, 0, 20, 0});

        dim_reg[0] = etm_pkg::RST_BASE_DIM;
        dim_reg[1] = etm_pkg::RST_BASE_DIM;
        dim_reg[2] = etm_pkg::RST_TEMPL_DIM;
        dim_reg[3] = etm_pkg::RST_TEMPL_DIM;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (phases[pi])
        begin
            ph = phases[pi];
            wait_idle();
            write_dim(etm_pkg::CFG_BASE_W, ph.bw);
            write_dim(etm_pkg::CFG_BASE_H, ph.bh);
            write_dim(etm_pkg::CFG_TEMPL_W, ph.tw);
            write_dim(etm_pkg::CFG_TEMPL_H, ph.th);
            cfg_valid <= 1'b0;
            send_idle = ph.send_idle;
            recv_stall = ph.recv_stall;
            bw = clamp_dim(ph.bw);
            bh = clamp_dim(ph.bh);
            tw = clamp_dim(ph.tw);
            th = clamp_dim(ph.th);
            if (pi == 0)
            begin
                fill(etm_pkg::FN_WR_BASE, bw, bh, 0);
                fill(etm_pkg::FN_WR_TEMPL, tw, th, 0);
                queue_item(etm_pkg::FN_SEARCH, 0, 0, 0);
                fill(etm_pkg::FN_WR_TEMPL, tw, th, 255);
                queue_item(etm_pkg::FN_SEARCH, 255, 255, 255);
                queue_item(etm_pkg::FN_WR_BASE, 5, 4, 255);
                queue_item(etm_pkg::FN_SEARCH, 0, 0, 0);
                fill(etm_pkg::FN_WR_BASE, bw, bh, 7);
                queue_item(etm_pkg::FN_SEARCH, 0, 0, 0);
                queue_item(etm_pkg::FN_WR_BASE, 255, 255, 170);
                queue_item(etm_pkg::FN_WR_TEMPL, 255, 255, 85);
                queue_item(FN_UNUSED, 1, 1, 1);
                queue_item(etm_pkg::FN_WR_BASE, 7, 5, 255);
                queue_item(etm_pkg::FN_WR_TEMPL, 2, 1, 1);
                queue_item(etm_pkg::FN_SEARCH, 0, 0, 0);
            end
            fill(etm_pkg::FN_WR_BASE, bw, bh, -1);
            fill(etm_pkg::FN_WR_TEMPL, tw, th, -1);
            if (ph.long_hold)
                hold_arm = 1'b1;
            for (int n = 0; n < ph.n_rand; n++)
            begin
                k = $urandom_range(99);
                if (k < 10)
                    queue_item(etm_pkg::FN_SEARCH, $urandom_range(255), $urandom_range(255),
                               rand_pix());
                else if (k < 13)
                    queue_item(FN_UNUSED, $urandom_range(255), $urandom_range(255),
                               $urandom_range(255));
                else if (k < 18)
                    queue_item(etm_pkg::FUNC_W'($urandom_range(1)), $urandom_range(255),
                               $urandom_range(255), rand_pix());
                else if (k < 60)
                    queue_item(etm_pkg::FN_WR_BASE, $urandom_range(bw - 1),
                               $urandom_range(bh - 1), rand_pix());
                else
                    queue_item(etm_pkg::FN_WR_TEMPL, $urandom_range(tw - 1),
                               $urandom_range(th - 1), rand_pix());
            end
            queue_item(etm_pkg::FN_SEARCH, 0, 0, 0);
        end

        wait_idle();
        if (errors == 0 && expected_matches.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
